// ===== design/pfa_pkg.sv =====
// Package for partition_fit_allocator: transaction payload types, operation,
// policy and status codes, and the sequencer state type. No dependencies.
`default_nettype none
package pfa_pkg;

  localparam int unsigned SIZE_W = 24;
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_HOUSE = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_RSVD  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] size_units;
    logic        busy_flag;
    logic [15:0] job_id;
    logic [15:0] run_time;
    logic [1:0]  policy;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
    logic [4:0] released_count;
    logic [4:0] entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC_END,
    S_RELEASE,
    S_COMPACT,
    S_MERGE,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== design/partition_fit_allocator.sv =====
// Top level of partition_fit_allocator: partition table and the sequencer that
// walks it one entry per cycle. Depends on pfa_pkg.
//
// Usage: the in_ channel carries one operation (load, allocate, housekeeping)
// per transaction; the out_ channel returns exactly one result per operation.
// The block takes one operation at a time: in_stall is high from acceptance
// until the cycle after the result has been taken by the receiver.
// Steps of each operation between acceptance and the raising of out_valid:
//   load: the entry is written at the accepting edge itself.
//   allocate: a scan over the entries, then the leftover partition, if any, is
//   appended before the allocated entry is written; first fit stops at the first fitting entry.
//   housekeeping: one release pass, one compact pass, then the merge.
// The block does not take a new operation before the last result is taken; it
// has a single registered table read port and a shared compare/subtract unit.
// Reset empties the table (entry count zero); entry contents are not cleared.
// While out_stall is high, out_valid and out_data hold and no new operation
// is accepted.
`default_nettype none
module partition_fit_allocator #(
  parameter int unsigned MAX_PARTS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire pfa_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output pfa_pkg::out_item_t    out_data
);

  localparam int unsigned IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);

  logic [23:0] size_m  [MAX_PARTS];
  logic        busy_m  [MAX_PARTS];
  logic [15:0] job_m   [MAX_PARTS];
  logic [31:0] start_m [MAX_PARTS];
  logic [15:0] rt_m    [MAX_PARTS];

  pfa_pkg::state_t state_r, state_nxt;
  pfa_pkg::in_item_t req_r;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [23:0]   best_r, best_nxt;
  logic [23:0]   fsum_r, fsum_nxt;
  logic          anyf_r, anyf_nxt;
  logic [CW-1:0] rel_r, rel_nxt;
  pfa_pkg::out_item_t res_r, res_nxt;
  logic          ovalid_r, ovalid_nxt;

  logic          we;
  logic [IW-1:0] wa;
  logic [23:0]   wsize;
  logic          wbusy;
  logic [15:0]   wjob;
  logic [31:0]   wstart;
  logic [15:0]   wrt;

  logic [IW-1:0] ri;
  logic [IW-1:0] ra;
  logic [23:0]   e_size_r;
  logic          e_busy_r;
  logic [15:0]   e_job_r;
  logic [31:0]   e_start_r;
  logic [15:0]   e_rt_r;
  logic [23:0]   left;
  logic [24:0]   sum;
  logic          elapsed;
  logic          full;

  assign ri      = idx_r[IW-1:0];
  assign ra      = idx_nxt[IW-1:0];
  assign left    = e_size_r - req_r.size_units;
  assign sum     = {1'b0, fsum_r} + {1'b0, e_size_r};
  assign elapsed = (req_r.now - e_start_r) >= {16'd0, e_rt_r};
  assign full    = (total_r >= CW'(MAX_PARTS));

  assign in_stall  = (state_r != pfa_pkg::S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (we) begin
      size_m[wa]  <= wsize;
      busy_m[wa]  <= wbusy;
      job_m[wa]   <= wjob;
      start_m[wa] <= wstart;
      rt_m[wa]    <= wrt;
    end
    e_size_r  <= size_m[ra];
    e_busy_r  <= busy_m[ra];
    e_job_r   <= job_m[ra];
    e_start_r <= start_m[ra];
    e_rt_r    <= rt_m[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pfa_pkg::S_IDLE;
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pfa_pkg::S_IDLE && in_valid) begin
      req_r <= in_data;
    end
    idx_r   <= idx_nxt;
    wr_r    <= wr_nxt;
    found_r <= found_nxt;
    pick_r  <= pick_nxt;
    best_r  <= best_nxt;
    fsum_r  <= fsum_nxt;
    anyf_r  <= anyf_nxt;
    rel_r   <= rel_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    wr_nxt     = wr_r;
    found_nxt  = found_r;
    pick_nxt   = pick_r;
    best_nxt   = best_r;
    fsum_nxt   = fsum_r;
    anyf_nxt   = anyf_r;
    rel_nxt    = rel_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r;
    we     = 1'b0;
    wa     = ri;
    wsize  = e_size_r;
    wbusy  = 1'b0;
    wjob   = '0;
    wstart = '0;
    wrt    = '0;
    unique case (state_r)
      pfa_pkg::S_IDLE: begin
        idx_nxt   = '0;
        wr_nxt    = '0;
        found_nxt = 1'b0;
        pick_nxt  = '0;
        best_nxt  = '0;
        fsum_nxt  = '0;
        anyf_nxt  = 1'b0;
        rel_nxt   = '0;
        res_nxt   = '0;
        if (in_valid) begin
          priority case (in_data.func)
            pfa_pkg::FUNC_LOAD: begin
              if (in_data.size_units != '0) begin
                if (full) begin
                  res_nxt.status = pfa_pkg::ST_FULL;
                end else begin
                  we     = 1'b1;
                  wa     = total_r[IW-1:0];
                  wsize  = in_data.size_units;
                  wbusy  = in_data.busy_flag;
                  wjob   = in_data.busy_flag ? in_data.job_id : 16'd0;
                  wstart = in_data.busy_flag ? in_data.now : 32'd0;
                  wrt    = in_data.busy_flag ? in_data.run_time : 16'd0;
                  res_nxt.slot_index = 4'(total_r);
                  total_nxt = total_r + 1'b1;
                end
              end
              state_nxt = pfa_pkg::S_OUT;
            end
            pfa_pkg::FUNC_ALLOC: state_nxt = pfa_pkg::S_SCAN;
            pfa_pkg::FUNC_HOUSE: state_nxt = pfa_pkg::S_RELEASE;
            default: state_nxt = pfa_pkg::S_OUT;
          endcase
        end
      end
      pfa_pkg::S_SCAN: begin
        if (idx_r >= total_r) begin
          state_nxt = pfa_pkg::S_ALLOC_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (!e_busy_r && e_size_r >= req_r.size_units) begin
            if (!found_r) begin
              found_nxt = 1'b1;
              pick_nxt  = ri;
              best_nxt  = left;
              if (req_r.policy != pfa_pkg::POL_BEST && req_r.policy != pfa_pkg::POL_WORST) begin
                state_nxt = pfa_pkg::S_ALLOC_END;
              end
            end else if ((req_r.policy == pfa_pkg::POL_BEST && left < best_r) ||
                         (req_r.policy == pfa_pkg::POL_WORST && left > best_r)) begin
              pick_nxt = ri;
              best_nxt = left;
            end
          end
        end
      end
      pfa_pkg::S_ALLOC_END: begin
        if (!found_r) begin
          res_nxt.status = pfa_pkg::ST_NOFIT;
          state_nxt = pfa_pkg::S_OUT;
        end else if (best_r != '0 && full) begin
          res_nxt.status = pfa_pkg::ST_FULL;
          state_nxt = pfa_pkg::S_OUT;
        end else if (best_r != '0) begin
          we    = 1'b1;
          wa    = total_r[IW-1:0];
          wsize = best_r;
          total_nxt = total_r + 1'b1;
          best_nxt  = '0;
        end else begin
          we     = 1'b1;
          wa     = pick_r;
          wsize  = req_r.size_units;
          wbusy  = 1'b1;
          wjob   = req_r.job_id;
          wstart = req_r.now;
          wrt    = req_r.run_time;
          res_nxt.slot_index = 4'(pick_r);
          state_nxt = pfa_pkg::S_OUT;
        end
      end
      pfa_pkg::S_RELEASE: begin
        if (idx_r >= total_r) begin
          idx_nxt   = '0;
          state_nxt = pfa_pkg::S_COMPACT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (e_busy_r && elapsed) begin
            we      = 1'b1;
            rel_nxt = rel_r + 1'b1;
          end
        end
      end
      pfa_pkg::S_COMPACT: begin
        if (idx_r >= total_r) begin
          state_nxt = pfa_pkg::S_MERGE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (e_busy_r) begin
            we     = 1'b1;
            wa     = wr_r[IW-1:0];
            wbusy  = 1'b1;
            wjob   = e_job_r;
            wstart = e_start_r;
            wrt    = e_rt_r;
            wr_nxt = wr_r + 1'b1;
          end else begin
            anyf_nxt = 1'b1;
            fsum_nxt = sum[24] ? pfa_pkg::SIZE_MAX : sum[23:0];
          end
        end
      end
      pfa_pkg::S_MERGE: begin
        if (anyf_r) begin
          we    = 1'b1;
          wa    = wr_r[IW-1:0];
          wsize = fsum_r;
          total_nxt = wr_r + 1'b1;
        end else begin
          total_nxt = wr_r;
        end
        res_nxt.released_count = 5'(rel_r);
        state_nxt = pfa_pkg::S_OUT;
      end
      pfa_pkg::S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          res_nxt.entry_count = 5'(total_r);
        end else if (!out_stall) begin
          ovalid_nxt = 1'b0;
          state_nxt  = pfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = pfa_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
